// ===== sv/pgrrip_pkg.sv =====
// ----------------------------------------------------------------------------
// pgrrip_pkg
// Shared types and constants of the PC-guided RRIP replacement policy.
// ----------------------------------------------------------------------------
`default_nettype none

package pgrrip_pkg;

	localparam int DEF_NUM_SETS     = 2048;
	localparam int DEF_NUM_WAYS     = 16;
	localparam int DEF_HASH_BITS    = 11;
	localparam int DEF_DUEL_PERIOD  = 64;
	localparam int DEF_LEADER_SPAN  = 32;
	localparam int DEF_SEL_BITS     = 10;

	localparam int SET_W      = 11;
	localparam int WAY_W      = 4;
	localparam int PC_W       = 64;
	localparam int VICTIM_W   = 4;
	localparam int DUEL_OUT_W = 10;
	localparam int THR_W      = 3;
	localparam int AGE_W      = 2;
	localparam int REUSE_W    = 3;
	localparam int CFG_IDX_W  = 1;

	localparam int HASH_SH_A  = 12;
	localparam int HASH_SH_B  = 22;
	localparam int NEAR_W     = 5;

	localparam logic MODE_VICTIM = 1'b0;
	localparam logic MODE_UPDATE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROMOTE = 1'b1;

	localparam logic [AGE_W-1:0] AGE_ZERO = 2'd0;
	localparam logic [AGE_W-1:0] AGE_NEAR = 2'd2;
	localparam logic [AGE_W-1:0] AGE_MAX  = 2'd3;

	localparam logic [REUSE_W-1:0] REUSE_MAX  = 3'd7;
	localparam logic [REUSE_W-1:0] REUSE_INIT = 3'd3;

	localparam logic [THR_W-1:0] BYPASS_INIT  = 3'd1;
	localparam logic [THR_W-1:0] PROMOTE_INIT = 3'd5;

	typedef struct packed {
		logic                mode;
		logic [SET_W-1:0]    set_index;
		logic [WAY_W-1:0]    way;
		logic [PC_W-1:0]     pc;
		logic                hit;
	} req_t;

	typedef struct packed {
		logic [VICTIM_W-1:0]   victim_way;
		logic [DUEL_OUT_W-1:0] duel_selector;
	} rsp_t;

	function automatic logic [PC_W-1:0] pc_hash(input logic [PC_W-1:0] pc);
		return pc ^ (pc >> HASH_SH_A) ^ (pc >> HASH_SH_B);
	endfunction

endpackage

`default_nettype wire

// ===== sv/pc_guided_rrip_dip_replacement.sv =====
// ----------------------------------------------------------------------------
// pc_guided_rrip_dip_replacement
// Last-level cache replacement policy: 2-bit re-reference ages and used bits
// per line in one row memory, 3-bit PC-hashed reuse counters in a second
// memory, and a saturating duel selector choosing LRU or bimodal insertion.
// Each request beat has two steps: the accept edge reads the set row and
// the reuse entry; the edge that leaves ST_EXEC modifies them, writes back
// the row (and, for an update, the reuse entry) and loads the response
// register. A new request is taken only once the beat is back in ST_IDLE,
// and a stalled response holds the write-back cycle. After reset a clearing
// pass initializes both memories; req_stall stays high during it,
// configuration writes are taken as ever.
// ----------------------------------------------------------------------------
`default_nettype none

module pc_guided_rrip_dip_replacement
	import pgrrip_pkg::*;
#(
	parameter int NUM_SETS     = DEF_NUM_SETS,
	parameter int NUM_WAYS     = DEF_NUM_WAYS,
	parameter int HASH_BITS    = DEF_HASH_BITS,
	parameter int DUEL_PERIOD  = DEF_DUEL_PERIOD,
	parameter int LEADER_SPAN  = DEF_LEADER_SPAN,
	parameter int SEL_BITS     = DEF_SEL_BITS
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  cfg_wr_en,
	input  wire [CFG_IDX_W-1:0]  cfg_index,
	input  wire [THR_W-1:0]      cfg_data,
	input  wire                  req_valid,
	output logic                 req_stall,
	input  wire req_t            req,
	output logic                 rsp_valid,
	input  wire                  rsp_stall,
	output rsp_t                 rsp
);

	localparam int SETW     = $clog2(NUM_SETS);
	localparam int WIDX     = $clog2(NUM_WAYS);
	localparam int SIG_SIZE = 1 << HASH_BITS;
	localparam int CLR_LEN  = (NUM_SETS > SIG_SIZE) ? NUM_SETS : SIG_SIZE;
	localparam int CLRW     = $clog2(CLR_LEN);
	localparam int EXTW     = (SEL_BITS > DUEL_OUT_W) ? SEL_BITS : DUEL_OUT_W;

	localparam logic [SEL_BITS-1:0] SEL_MAX = {SEL_BITS{1'b1}};
	localparam logic [SEL_BITS-1:0] SEL_MID = SEL_MAX >> 1;

	// set modulo NUM_SETS by reciprocal multiplication, exact for 11-bit sets
	localparam int SM_S  = SET_W + $clog2(NUM_SETS);
	localparam int SM_PW = SET_W + SM_S + 1;
	localparam logic [SM_PW-1:0] SM_M =
		SM_PW'(((64'd1 << SM_S) + 64'(NUM_SETS) - 64'd1) / 64'(NUM_SETS));

	// set modulo DUEL_PERIOD, same scheme
	localparam int DP_S  = SETW + $clog2(DUEL_PERIOD);
	localparam int DP_PW = SETW + DP_S + 1;
	localparam logic [DP_PW-1:0] DP_M =
		DP_PW'(((64'd1 << DP_S) + 64'(DUEL_PERIOD) - 64'd1) / 64'(DUEL_PERIOD));

	typedef logic [NUM_WAYS-1:0][AGE_W:0] row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t                 state_q;
	logic [CLRW-1:0]        clr_q;
	logic [SEL_BITS-1:0]    duel_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;
	logic [THR_W-1:0]       bypass_q;
	logic [THR_W-1:0]       promote_q;

	row_t                   line_mem [NUM_SETS];
	logic [REUSE_W-1:0]     reuse_mem [SIG_SIZE];

	row_t                   row_s1;
	logic [REUSE_W-1:0]     reuse_s1;
	logic                   mode_s1;
	logic [SETW-1:0]        set_s1;
	logic [WAY_W-1:0]       way_s1;
	logic                   hit_s1;
	logic [HASH_BITS-1:0]   sig_s1;
	logic                   near_s1;

	logic                   acc;
	logic                   go;
	logic                   clearing;
	logic [PC_W-1:0]        req_hash;
	logic [HASH_BITS-1:0]   req_sig;
	logic [SM_PW-1:0]       sm_prod;
	logic [SM_PW-1:0]       sm_q;
	logic [SM_PW-1:0]       sm_rem;
	logic [SETW-1:0]        set_mod;
	logic [DP_PW-1:0]       dp_prod;
	logic [DP_PW-1:0]       dp_q;
	logic [DP_PW-1:0]       dp_rem;
	logic                   lru_lead;
	logic                   bip_lead;

	logic                   any3;
	logic                   any2;
	logic                   any1;
	logic [AGE_W-1:0]       age_step;
	row_t                   aged_row;
	row_t                   upd_row;
	row_t                   clear_row;
	logic                   has_free;
	logic [WIDX-1:0]        free_idx;
	logic [WIDX-1:0]        any_idx;
	logic [WIDX-1:0]        victim;
	logic                   way_ok;
	logic [WIDX-1:0]        widx;
	logic [REUSE_W-1:0]     reuse_new;
	logic [SEL_BITS-1:0]    duel_new;
	logic [AGE_W-1:0]       ins_age;
	logic [EXTW-1:0]        sel_ext;
	rsp_t                   rsp_next;

	logic                   line_we;
	logic [SETW-1:0]        line_wa;
	row_t                   line_wd;
	logic                   reuse_we;
	logic [HASH_BITS-1:0]   reuse_wa;
	logic [REUSE_W-1:0]     reuse_wd;

	assign clearing  = (state_q == ST_CLEAR);
	assign req_stall = (state_q != ST_IDLE);
	assign acc       = req_valid && !req_stall;
	assign go        = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign req_hash = pc_hash(req.pc);
	assign req_sig  = req_hash[HASH_BITS-1:0];

	assign sm_prod = SM_PW'(req.set_index) * SM_M;
	assign sm_q    = sm_prod >> SM_S;
	assign sm_rem  = SM_PW'(req.set_index) - sm_q * SM_PW'(NUM_SETS);
	assign set_mod = sm_rem[SETW-1:0];

	assign dp_prod  = DP_PW'(set_s1) * DP_M;
	assign dp_q     = dp_prod >> DP_S;
	assign dp_rem   = DP_PW'(set_s1) - dp_q * DP_PW'(DUEL_PERIOD);
	assign lru_lead = dp_rem < DP_PW'(LEADER_SPAN);
	assign bip_lead = !lru_lead && (dp_rem < DP_PW'(2 * LEADER_SPAN));

	assign way_ok = int'(way_s1) < NUM_WAYS;
	assign widx   = WIDX'(way_s1);

	// victim side: age the row, then search for the first free or old way
	always_comb begin
		any3 = 1'b0;
		any2 = 1'b0;
		any1 = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			any3 |= (row_s1[w][AGE_W-1:0] == AGE_MAX);
			any2 |= (row_s1[w][AGE_W-1:0] == AGE_NEAR);
			any1 |= (row_s1[w][AGE_W-1:0] == 2'd1);
		end
		priority if (any3)
			age_step = 2'd0;
		else if (any2)
			age_step = 2'd1;
		else if (any1)
			age_step = 2'd2;
		else
			age_step = 2'd3;
		for (int w = 0; w < NUM_WAYS; w++) begin
			aged_row[w] = {row_s1[w][AGE_W], row_s1[w][AGE_W-1:0] + age_step};
			clear_row[w] = {1'b0, AGE_MAX};
		end
		has_free = 1'b0;
		free_idx = '0;
		any_idx  = '0;
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (aged_row[w][AGE_W-1:0] == AGE_MAX) begin
				any_idx = WIDX'(w);
				if (!aged_row[w][AGE_W]) begin
					has_free = 1'b1;
					free_idx = WIDX'(w);
				end
			end
		end
		victim = has_free ? free_idx : any_idx;
	end

	// update side: train predictor and selector, pick insertion age
	always_comb begin
		reuse_new = reuse_s1;
		duel_new  = duel_q;
		ins_age   = AGE_MAX;
		upd_row   = row_s1;
		if (mode_s1 == MODE_UPDATE) begin
			if (hit_s1) begin
				if (reuse_s1 != REUSE_MAX)
					reuse_new = reuse_s1 + 1'b1;
				if (way_ok)
					upd_row[widx] = {1'b1, AGE_ZERO};
			end else begin
				if (reuse_s1 != '0)
					reuse_new = reuse_s1 - 1'b1;
				if (lru_lead) begin
					if (duel_q != '0)
						duel_new = duel_q - 1'b1;
				end else if (bip_lead) begin
					if (duel_q != SEL_MAX)
						duel_new = duel_q + 1'b1;
				end
				priority if (reuse_new <= bypass_q)
					ins_age = AGE_MAX;
				else if (reuse_new >= promote_q)
					ins_age = AGE_ZERO;
				else if (lru_lead || (!bip_lead && (duel_new > SEL_MID)))
					ins_age = AGE_ZERO;
				else
					ins_age = near_s1 ? AGE_NEAR : AGE_MAX;
				if (way_ok)
					upd_row[widx] = {1'b0, ins_age};
			end
		end
		sel_ext = EXTW'(duel_new);
		rsp_next.victim_way    = (mode_s1 == MODE_UPDATE) ? '0 : VICTIM_W'(victim);
		rsp_next.duel_selector = sel_ext[DUEL_OUT_W-1:0];
	end

	always_comb begin
		line_we  = 1'b0;
		line_wa  = set_s1;
		line_wd  = (mode_s1 == MODE_UPDATE) ? upd_row : aged_row;
		reuse_we = 1'b0;
		reuse_wa = sig_s1;
		reuse_wd = reuse_new;
		if (clearing) begin
			line_we  = {1'b0, clr_q} < (CLRW + 1)'(NUM_SETS);
			line_wa  = clr_q[SETW-1:0];
			line_wd  = clear_row;
			reuse_we = {1'b0, clr_q} < (CLRW + 1)'(SIG_SIZE);
			reuse_wa = clr_q[HASH_BITS-1:0];
			reuse_wd = REUSE_INIT;
		end else if (state_q == ST_EXEC && go) begin
			line_we  = (mode_s1 == MODE_VICTIM) || way_ok;
			reuse_we = (mode_s1 == MODE_UPDATE);
		end
	end

	always_ff @(posedge clk) begin
		if (line_we)
			line_mem[line_wa] <= line_wd;
		if (acc)
			row_s1 <= line_mem[set_mod];
	end

	always_ff @(posedge clk) begin
		if (reuse_we)
			reuse_mem[reuse_wa] <= reuse_wd;
		if (acc)
			reuse_s1 <= reuse_mem[req_sig];
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			mode_s1 <= req.mode;
			set_s1  <= set_mod;
			way_s1  <= req.way;
			hit_s1  <= req.hit;
			sig_s1  <= req_sig;
			near_s1 <= (req_hash[NEAR_W-1:0] == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q  <= BYPASS_INIT;
			promote_q <= PROMOTE_INIT;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_BYPASS:  bypass_q  <= cfg_data;
				CFG_PROMOTE: promote_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			duel_q      <= SEL_MID;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (state_q == ST_EXEC && go)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLRW'(CLR_LEN - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (acc)
						state_q <= ST_EXEC;
				end
				ST_EXEC: begin
					if (go) begin
						state_q <= ST_IDLE;
						duel_q  <= duel_new;
						rsp_q   <= rsp_next;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_one_beat_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> req_stall)
		else $error("request accepted while previous beat in flight");

	a_duel_moves_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(duel_q) |-> $past(state_q == ST_EXEC && mode_s1 == MODE_UPDATE && !hit_s1))
		else $error("duel selector changed outside a miss update");

	a_quiet_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!rsp_valid && req_stall))
		else $error("traffic during clearing pass");
`endif

endmodule

`default_nettype wire

// ===== verif/pc_guided_rrip_dip_replacement_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pc_guided_rrip_dip_replacement_tb
// Drives victim queries, hits and miss fills into the replacement policy
// under random valid and stall gaps, predicts every response beat from a
// private copy of the line ages, used bits, reuse counters and duel selector,
// and compares each accepted response field by field. Threshold registers
// are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------

module pc_guided_rrip_dip_replacement_tb;
	import pgrrip_pkg::*;

	localparam int N_SETS         = DEF_NUM_SETS;
	localparam int N_WAYS         = DEF_NUM_WAYS;
	localparam int N_LINES        = N_SETS * N_WAYS;
	localparam int SIG_ENTRIES    = 1 << DEF_HASH_BITS;
	localparam int DUEL_P         = DEF_DUEL_PERIOD;
	localparam int LEADER_Q       = DEF_LEADER_SPAN;
	localparam int SEL_MAX        = (1 << DEF_SEL_BITS) - 1;
	localparam int GAP_MAX        = 12;
	localparam int RSP_HOLD       = 400;
	localparam int WATCHDOG_LIMIT = 6000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [THR_W-1:0]     cfg_data;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;

	int                   gap_max = GAP_MAX;
	bit                   hold_rsp = 1'b0;
	logic [PC_W-1:0]      pc_pool [16];

	class replacement_scoreboard;
		logic [AGE_W-1:0]         line_age [N_LINES];
		bit                       used_bit [N_LINES];
		logic [REUSE_W-1:0]       reuse_cnt [SIG_ENTRIES];
		logic [DEF_SEL_BITS-1:0]  duel_cnt;
		logic [THR_W-1:0]         bypass_thr;
		logic [THR_W-1:0]         promote_thr;
		logic [WAY_W-1:0]         last_victim;
		rsp_t                     expected_q[$];
		int                       errors;

		function new();
			int k;
			for (k = 0; k < N_LINES; k++) begin
				line_age[k] = AGE_MAX;
				used_bit[k] = 1'b0;
			end
			for (k = 0; k < SIG_ENTRIES; k++)
				reuse_cnt[k] = REUSE_INIT;
			duel_cnt = DEF_SEL_BITS'(SEL_MAX / 2);
			bypass_thr = BYPASS_INIT;
			promote_thr = PROMOTE_INIT;
			last_victim = '0;
			errors = 0;
		endfunction

		function void note_request(req_t r);
			int                 base;
			int                 w;
			int                 sig;
			int                 slot;
			bit                 found;
			bit                 lru_lead;
			bit                 bip_lead;
			bit                 use_lru;
			logic [AGE_W-1:0]   oldest;
			logic [AGE_W-1:0]   fill_age;
			logic [REUSE_W-1:0] cnt;
			logic [PC_W-1:0]    h;
			rsp_t               e;
			base = (int'(r.set_index) % N_SETS) * N_WAYS;
			e.victim_way = '0;
			if (r.mode == MODE_VICTIM) begin
				oldest = AGE_ZERO;
				for (w = 0; w < N_WAYS; w++)
					if (line_age[base + w] > oldest)
						oldest = line_age[base + w];
				if (oldest != AGE_MAX)
					for (w = 0; w < N_WAYS; w++)
						line_age[base + w] = line_age[base + w] + (AGE_MAX - oldest);
				found = 1'b0;
				for (w = 0; w < N_WAYS; w++)
					if (!found && line_age[base + w] == AGE_MAX && !used_bit[base + w]) begin
						e.victim_way = VICTIM_W'(w);
						found = 1'b1;
					end
				for (w = 0; w < N_WAYS; w++)
					if (!found && line_age[base + w] == AGE_MAX) begin
						e.victim_way = VICTIM_W'(w);
						found = 1'b1;
					end
				last_victim = e.victim_way;
			end else begin
				h = r.pc ^ (r.pc >> HASH_SH_A) ^ (r.pc >> HASH_SH_B);
				sig = int'(h[DEF_HASH_BITS-1:0]);
				if (r.hit) begin
					if (reuse_cnt[sig] != REUSE_MAX)
						reuse_cnt[sig]++;
					if (int'(r.way) < N_WAYS) begin
						line_age[base + r.way] = AGE_ZERO;
						used_bit[base + r.way] = 1'b1;
					end
				end else begin
					slot = (int'(r.set_index) % N_SETS) % DUEL_P;
					lru_lead = slot < LEADER_Q;
					bip_lead = !lru_lead && slot < 2 * LEADER_Q;
					if (reuse_cnt[sig] != 0)
						reuse_cnt[sig]--;
					if (lru_lead) begin
						if (duel_cnt != 0)
							duel_cnt--;
					end else if (bip_lead) begin
						if (duel_cnt != SEL_MAX)
							duel_cnt++;
					end
					cnt = reuse_cnt[sig];
					if (cnt <= bypass_thr) begin
						fill_age = AGE_MAX;
					end else if (cnt >= promote_thr) begin
						fill_age = AGE_ZERO;
					end else begin
						use_lru = lru_lead || (!bip_lead && duel_cnt > SEL_MAX / 2);
						if (use_lru)
							fill_age = AGE_ZERO;
						else
							fill_age = (h[NEAR_W-1:0] == 0) ? AGE_NEAR : AGE_MAX;
					end
					if (int'(r.way) < N_WAYS) begin
						line_age[base + r.way] = fill_age;
						used_bit[base + r.way] = 1'b0;
					end
				end
			end
			e.duel_selector = duel_cnt[DUEL_OUT_W-1:0];
			expected_q.push_back(e);
		endfunction

		function void check_response(rsp_t got);
			rsp_t e;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected response victim_way=%0d duel_selector=%0d",
					$time, got.victim_way, got.duel_selector);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (got.victim_way !== e.victim_way) begin
				$display("%0t: victim_way expected %0d actual %0d",
					$time, e.victim_way, got.victim_way);
				errors++;
			end
			if (got.duel_selector !== e.duel_selector) begin
				$display("%0t: duel_selector expected %0d actual %0d",
					$time, e.duel_selector, got.duel_selector);
				errors++;
			end
		endfunction
	endclass

	replacement_scoreboard sb;

	pc_guided_rrip_dip_replacement DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(req);
			if (rsp_valid && !rsp_stall)
				sb.check_response(rsp);
		end
	end

	initial begin
		int idle;
		idle = 0;
		while (idle < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle = 0;
			else
				idle++;
		end
		$display("pc_guided_rrip_dip_replacement_tb NOT OK");
		$finish;
	end

	// response side: random stalls per beat, one long hold on request
	initial begin
		int gap;
		rsp_stall = 1'b0;
		@(negedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_stall <= 1'b1;
				repeat (RSP_HOLD) @(negedge clk);
				hold_rsp = 1'b0;
			end
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	function automatic req_t mk(input logic mode_bit, input int set_no, input int way_no,
			input logic [PC_W-1:0] pc_val, input logic hit_bit);
		req_t r;
		r.mode = mode_bit;
		r.set_index = SET_W'(set_no);
		r.way = WAY_W'(way_no);
		r.pc = pc_val;
		r.hit = hit_bit;
		return r;
	endfunction

	// enter and leave at a falling edge; valid stays up for a back-to-back beat
	task automatic send(input req_t item);
		int gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_thresholds(input logic [THR_W-1:0] bypass,
			input logic [THR_W-1:0] promote);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_BYPASS;
		cfg_data <= bypass;
		@(negedge clk);
		cfg_index <= CFG_PROMOTE;
		cfg_data <= promote;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.bypass_thr = bypass;
		sb.promote_thr = promote;
	endtask

	// mostly victim query then fill of that victim, plus hits and noise beats
	task automatic run_accesses(input int count, input int lru_pct, input int hit_pct);
		int              n;
		int              kind;
		int              set_no;
		logic [PC_W-1:0] p;
		n = 0;
		while (n < count) begin
			set_no = $urandom_range(0, 1) * 31 * DUEL_P
				+ (($urandom_range(0, 99) < lru_pct) ? 0 : LEADER_Q)
				+ $urandom_range(0, 1) * (LEADER_Q - 1);
			p = pc_pool[$urandom_range(0, 15)];
			kind = $urandom_range(0, 99);
			if (kind < 10) begin
				send(mk(1'($urandom_range(0, 1)), $urandom_range(0, N_SETS - 1),
					$urandom_range(0, N_WAYS - 1), {$urandom, $urandom},
					1'($urandom_range(0, 1))));
				n++;
			end else if (kind < 10 + hit_pct) begin
				send(mk(MODE_UPDATE, set_no, $urandom_range(0, N_WAYS - 1), p, 1'b1));
				n++;
			end else begin
				send(mk(MODE_VICTIM, set_no, $urandom_range(0, N_WAYS - 1),
					{$urandom, $urandom}, 1'($urandom_range(0, 1))));
				send(mk(MODE_UPDATE, set_no, int'(sb.last_victim), p, 1'b0));
				n += 2;
			end
		end
	endtask

	initial begin
		int              i;
		logic [PC_W-1:0] p;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_BYPASS;
		cfg_data = '0;
		sb = new();
		// odd entries random, even entries hash to zero in the near-insertion bits
		for (i = 0; i < 16; i++) begin
			p = {$urandom, $urandom};
			if (i % 2 == 0)
				p[4:0] = p[16:12] ^ p[26:22];
			pc_pool[i] = p;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		set_thresholds(BYPASS_INIT, PROMOTE_INIT);

		send(mk(MODE_VICTIM, 0, 0, '0, 1'b0));
		send(mk(MODE_UPDATE, 0, 0, '0, 1'b1));
		send(mk(MODE_VICTIM, 0, 15, '1, 1'b1));
		send(mk(MODE_UPDATE, 0, 1, '0, 1'b0));
		send(mk(MODE_UPDATE, 32, 15, '0, 1'b0));
		send(mk(MODE_UPDATE, 2047, 15, '1, 1'b0));
		for (i = 0; i < 3; i++)
			send(mk(MODE_UPDATE, 2047, 15, '1, 1'b1));
		send(mk(MODE_UPDATE, 2047, 7, '1, 1'b0));
		for (i = 0; i < 4; i++)
			send(mk(MODE_UPDATE, 2047, 7, '1, 1'b1));
		send(mk(MODE_UPDATE, 1, 3, '1, 1'b0));
		for (i = 0; i < 3; i++)
			send(mk(MODE_UPDATE, 2, 2, '0, 1'b0));
		send(mk(MODE_VICTIM, 2047, 0, '0, 1'b0));
		send(mk(MODE_VICTIM, 32, 0, '0, 1'b0));
		send(mk(MODE_UPDATE, 1024, 8, 64'h5555_5555_5555_5555, 1'b1));
		send(mk(MODE_UPDATE, 1087, 8, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
		drain();

		set_thresholds(3'd0, 3'd7);
		hold_rsp = 1'b1;
		run_accesses(250, 50, 35);
		drain();

		set_thresholds(3'd2, 3'd4);
		run_accesses(1100, 100, 0);
		drain();

		set_thresholds(3'd7, 3'd0);
		run_accesses(200, 0, 40);
		drain();

		gap_max = 0;
		set_thresholds(3'd3, 3'd6);
		run_accesses(80, 50, 30);
		drain();

		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("pc_guided_rrip_dip_replacement_tb OK");
		else
			$display("pc_guided_rrip_dip_replacement_tb NOT OK");
		$finish;
	end

endmodule
